### sv/rwb_pkg.sv
// Package for the retransmit window buffer.
// Holds sizes, operation and status codes, register indexes and the stream
// item layouts. Depends on nothing.
package rwb_pkg;

  localparam int DEPTH     = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SEQ_W     = 8;
  localparam int HANDLE_W  = 16;
  localparam int STAMP_W   = 32;
  localparam int TIMEOUT_W = 16;
  localparam int CAP_W     = 6;
  localparam int PEER_W    = 8;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 6;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;

  localparam logic [CAP_W-1:0]     CAPACITY_RESET = 6'd32;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd4;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic [4:0]          pad;
    logic [PEER_W-1:0]   peer_window;
    logic [HANDLE_W-1:0] packet_handle;
    logic [SEQ_W-1:0]    seq_number;
    logic [OP_W-1:0]     op;
  } in_item_t;

  typedef struct packed {
    logic [6:0]          pad;
    logic                is_full;
    logic [OCC_W-1:0]    occupancy;
    logic [HANDLE_W-1:0] hit_handle;
    logic [SEQ_W-1:0]    hit_seq_number;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

### sv/retransmit_window_buffer_top.sv
// Retransmit window buffer: ring of entries in one synchronous memory,
// with a sequencer that appends, scans and drops entries.
// Depends on rwb_pkg.
// Add, tick, query full and unused codes answer without a scan; ack, find
// and check timeout scan from the oldest entry until one hits or the newest
// entry has been read, and answer without a scan when the window is empty.
// Throughput: one request at a time; the scan reads one memory entry a cycle.
// A new request is taken while the previous result waits at the output.
// Reset clears occupancy and tick counter and restores the registers to their
// reset values; memory is not cleared.
module retransmit_window_buffer_top
  import rwb_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op, seq_number, packet_handle, peer_window
  input  logic [rwb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, hit_seq_number, hit_handle, occupancy, is_full
  output logic [rwb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [rwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [CAP_W-1:0]     capacity;
  logic [TIMEOUT_W-1:0] timeout;
  logic [CNT_W-1:0]     count;
  logic [ADDR_W-1:0]    head;
  logic [STAMP_W-1:0]   tick;

  logic [OP_W-1:0]      req_op;
  logic [SEQ_W-1:0]     req_seq;
  logic [PEER_W-1:0]    req_peer;
  logic [CNT_W-1:0]     iss;
  logic [CNT_W-1:0]     rd_idx;

  logic [STATUS_W-1:0]  res_status;
  logic [SEQ_W-1:0]     res_seq;
  logic [HANDLE_W-1:0]  res_handle;

  entry_t               mem [DEPTH];
  entry_t               rd_data;
  entry_t               wr_entry;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 mem_we;

  in_item_t             in_item;
  out_item_t            out_item;
  logic                 accept;
  logic                 out_load;
  logic [CNT_W-1:0]     cap;
  logic                 room;
  logic                 scan_op;
  logic [STAMP_W-1:0]   age;
  logic                 hit;
  logic                 last;
  logic [CNT_W-1:0]     drop_n;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign cap     = (capacity > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  assign room    = (count < cap);
  assign scan_op = (in_item.op == OP_ACK) || (in_item.op == OP_FIND) ||
                   (in_item.op == OP_CHECK);

  assign mem_we   = accept && (in_item.op == OP_ADD) && room;
  assign wr_addr  = head + count[ADDR_W-1:0];
  assign wr_entry = '{seq: in_item.seq_number,
                      handle: in_item.packet_handle[HANDLE_W-1:0],
                      stamp: tick};
  assign rd_addr  = (state == S_SCAN) ? head + iss[ADDR_W-1:0] : head;

  assign age    = tick - rd_data.stamp;
  assign hit    = (req_op == OP_CHECK) ? (age >= STAMP_W'(timeout))
                                       : (rd_data.seq == req_seq);
  assign last   = (rd_idx == count - CNT_W'(1));
  assign drop_n = rd_idx + CNT_W'(1);

  always_comb begin
    out_item                = '0;
    out_item.status         = res_status;
    out_item.hit_seq_number = res_seq;
    out_item.hit_handle     = res_handle;
    out_item.occupancy      = OCC_W'(count);
    out_item.is_full        = ({{PEER_W{1'b0}}, count} >= {{CNT_W{1'b0}}, req_peer});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= CAPACITY_RESET;
      timeout       <= TIMEOUT_RESET;
      count         <= '0;
      head          <= '0;
      tick          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
          CFG_TIMEOUT:  timeout  <= cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= OUT_TDATA_W'(out_item);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            req_op     <= in_item.op;
            req_seq    <= in_item.seq_number;
            req_peer   <= in_item.peer_window;
            res_seq    <= '0;
            res_handle <= '0;
            iss        <= CNT_W'(1);
            rd_idx     <= '0;
            if (in_item.op == OP_ADD) begin
              state <= S_DONE;
              if (room) begin
                count      <= count + CNT_W'(1);
                res_status <= ST_OK;
              end else begin
                res_status <= ST_FULL;
              end
            end else if (scan_op && (count != '0)) begin
              state      <= S_SCAN;
              res_status <= ST_OK;
            end else if (scan_op) begin
              state      <= S_DONE;
              res_status <= ST_NOT_FOUND;
            end else begin
              state      <= S_DONE;
              res_status <= ST_OK;
              if (in_item.op == OP_TICK) begin
                tick <= tick + STAMP_W'(1);
              end
            end
          end
        end
        S_SCAN: begin
          iss    <= iss + CNT_W'(1);
          rd_idx <= iss;
          if (hit) begin
            res_seq    <= rd_data.seq;
            res_handle <= rd_data.handle;
            state      <= S_DONE;
            if (req_op == OP_ACK) begin
              head  <= head + drop_n[ADDR_W-1:0];
              count <= count - drop_n;
            end
          end else if (last) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/rwb_checker.sv
// Port checker for the retransmit window buffer, bound to the top level.
// Depends on rwb_pkg and retransmit_window_buffer_top.
module rwb_checker
  import rwb_pkg::*;
(
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rwb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  out_item_t mo;

  assign mo = out_item_t'(m_axis_tdata);

  // ready must drop once a request is accepted, holding off a second one
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mo.status == ST_OK) || (mo.status == ST_FULL) ||
                      (mo.status == ST_NOT_FOUND))
    else $error("undefined status code");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mo.status != ST_OK) |->
      (mo.hit_seq_number == '0) && (mo.hit_handle == '0))
    else $error("hit fields set on a failed request");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mo.occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy beyond window depth");

endmodule

bind retransmit_window_buffer_top rwb_checker u_rwb_checker (.*);

### dv/retransmit_window_buffer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for retransmit_window_buffer_top: drives operation
// requests, predicts every response with its own window model and compares.
// Depends on rwb_pkg and retransmit_window_buffer_top.
module retransmit_window_buffer_top_tb;
  import rwb_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES    = 200;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  retransmit_window_buffer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // window model
  logic [SEQ_W-1:0]     win_seq[DEPTH];
  logic [HANDLE_W-1:0]  win_handle[DEPTH];
  logic [STAMP_W-1:0]   win_stamp[DEPTH];
  int unsigned          win_count;
  logic [STAMP_W-1:0]   now_ticks;
  logic [CAP_W-1:0]     cap_reg;
  logic [TIMEOUT_W-1:0] timeout_reg;

  in_item_t    request_q[$];
  out_item_t   expected_results[$];
  logic [SEQ_W-1:0] issued_seq[$];
  logic [SEQ_W-1:0] next_seq = '0;

  logic in_fire = 1'b0;
  logic idling = 1'b1;
  logic pressure_on = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_cnt = 0;
  int   quiet_cycles = 0;
  int   errors = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic out_item_t window_step(in_item_t req);
    out_item_t   res;
    int unsigned lim;
    int          hit;
    int          i;
    res = '0;
    res.status = ST_OK;
    lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    hit = -1;
    case (req.op)
      OP_ADD: begin
        if (win_count < lim) begin
          win_seq[win_count] = req.seq_number;
          win_handle[win_count] = req.packet_handle;
          win_stamp[win_count] = now_ticks;
          win_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_ACK, OP_FIND: begin
        for (i = 0; i < win_count; i++) begin
          if (hit < 0 && win_seq[i] == req.seq_number) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.hit_seq_number = win_seq[hit];
          res.hit_handle = win_handle[hit];
          if (req.op == OP_ACK) begin
            for (i = hit + 1; i < win_count; i++) begin
              win_seq[i - hit - 1] = win_seq[i];
              win_handle[i - hit - 1] = win_handle[i];
              win_stamp[i - hit - 1] = win_stamp[i];
            end
            win_count -= hit + 1;
          end
        end
      end
      OP_TICK: now_ticks = now_ticks + 1;
      OP_CHECK: begin
        for (i = 0; i < win_count; i++) begin
          if (hit < 0 && STAMP_W'(now_ticks - win_stamp[i]) >= timeout_reg) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.hit_seq_number = win_seq[hit];
          res.hit_handle = win_handle[hit];
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(win_count);
    res.is_full = (req.peer_window <= win_count);
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_request(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq,
                              logic [HANDLE_W-1:0] handle, logic [PEER_W-1:0] peer);
    in_item_t req;
    req = '0;
    req.op = op;
    req.seq_number = seq;
    req.packet_handle = handle;
    req.peer_window = peer;
    request_q.push_back(req);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = val[CAP_W-1:0];
    else timeout_reg = val[TIMEOUT_W-1:0];
  endtask

  task automatic drain();
    while (request_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly well-formed traffic: adds with rising sequence numbers, acks of the
  // oldest few outstanding, lookups of outstanding ones, with some noise
  task automatic random_requests(int n, int add_pct);
    int                  pick;
    int                  idx;
    int                  hi;
    logic [SEQ_W-1:0]    seq;
    logic [PEER_W-1:0]   peer;
    logic [OP_W-1:0]     op;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      peer = ($urandom_range(0, 3) == 0) ? PEER_W'($urandom_range(0, 255))
                                         : PEER_W'($urandom_range(0, 34));
      seq = SEQ_W'($urandom_range(0, 255));
      if (pick < add_pct) begin
        op = OP_ADD;
        if ($urandom_range(0, 9) != 0) begin
          seq = next_seq;
          next_seq = next_seq + 1;
        end
        issued_seq.push_back(seq);
        if (issued_seq.size() > 48) void'(issued_seq.pop_front());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          op = OP_ACK;
          if (issued_seq.size() != 0 && $urandom_range(0, 4) != 0) begin
            hi = (issued_seq.size() > 4) ? 3 : issued_seq.size() - 1;
            idx = $urandom_range(0, hi);
            seq = issued_seq[idx];
            repeat (idx + 1) void'(issued_seq.pop_front());
          end
        end else if (pick < 60) begin
          op = OP_FIND;
          if (issued_seq.size() != 0 && $urandom_range(0, 3) != 0)
            seq = issued_seq[$urandom_range(0, issued_seq.size() - 1)];
        end else if (pick < 80) begin
          op = OP_TICK;
        end else if (pick < 92) begin
          op = OP_CHECK;
        end else if (pick < 98) begin
          op = OP_QUERY;
        end else begin
          op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        end
      end
      push_request(op, seq, HANDLE_W'($urandom_range(0, 65535)), peer);
    end
  endtask

  // sender
  always @(negedge clk) begin : drive
    in_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0 && !(idling && $urandom_range(0, 7) == 0)) begin
        nxt = request_q.pop_front();
        s_axis_tdata <= nxt;
        s_axis_tvalid <= 1'b1;
      end else begin
        if (request_q.size() != 0) send_gap <= $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin : accept_side
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin : observe
    out_item_t got;
    out_item_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, status", got.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
          if (got.hit_seq_number !== want.hit_seq_number)
            flag_mismatch("hit_seq_number", got.hit_seq_number, want.hit_seq_number);
          if (got.hit_handle !== want.hit_handle)
            flag_mismatch("hit_handle", got.hit_handle, want.hit_handle);
          if (got.occupancy !== want.occupancy)
            flag_mismatch("occupancy", got.occupancy, want.occupancy);
          if (got.is_full !== want.is_full)
            flag_mismatch("is_full", got.is_full, want.is_full);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(window_step(s_axis_tdata));
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (request_q.size() == 0 && !s_axis_tvalid && expected_results.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    win_count = 0;
    now_ticks = '0;
    cap_reg = CAPACITY_RESET;
    timeout_reg = TIMEOUT_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // empty window, then duplicates, extremes, timeout and drop-through ack
    push_request(OP_QUERY, 8'h00, 16'h0000, 8'd0);
    push_request(OP_ACK,   8'h11, 16'h0000, 8'd255);
    push_request(OP_FIND,  8'h11, 16'hFFFF, 8'd0);
    push_request(OP_CHECK, 8'h00, 16'h0000, 8'd1);
    push_request(OP_ADD,   8'h00, 16'h0000, 8'd255);
    push_request(OP_ADD,   8'hFF, 16'hFFFF, 8'd1);
    push_request(OP_ADD,   8'h00, 16'h1234, 8'd3);
    push_request(OP_ADD,   8'h42, 16'hBEEF, 8'd4);
    push_request(OP_FIND,  8'h00, 16'h0000, 8'd5);
    push_request(OP_FIND,  8'hFF, 16'h0000, 8'd4);
    push_request(OP_CHECK, 8'h00, 16'h0000, 8'd0);
    repeat (4) push_request(OP_TICK, 8'hA5, 16'h5A5A, 8'd128);
    push_request(OP_CHECK, 8'hFF, 16'hFFFF, 8'd255);
    push_request(OP_ACK,   8'h99, 16'h0000, 8'd4);
    push_request(OP_ACK,   8'hFF, 16'h0000, 8'd2);
    push_request(OP_QUERY, 8'h00, 16'h0000, 8'd2);
    push_request(OP_SPARE_LO, 8'hFF, 16'hFFFF, 8'd255);
    push_request(OP_SPARE_HI, 8'h00, 16'h0000, 8'd0);
    push_request(OP_ACK,   8'h00, 16'h0000, 8'd1);
    drain();

    // zero capacity and zero timeout
    write_reg(CFG_CAPACITY, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd0);
    push_request(OP_ADD,   8'h77, 16'h0F0F, 8'd1);
    push_request(OP_CHECK, 8'h00, 16'h0000, 8'd1);
    push_request(OP_QUERY, 8'h00, 16'h0000, 8'd255);
    drain();

    write_reg(CFG_CAPACITY, 16'd40);
    write_reg(CFG_TIMEOUT, 16'd1);
    random_requests(120, 70);
    drain();

    write_reg(CFG_CAPACITY, 16'd5);
    write_reg(CFG_TIMEOUT, 16'd3);
    random_requests(120, 35);
    drain();

    write_reg(CFG_CAPACITY, 16'd63);
    write_reg(CFG_TIMEOUT, 16'd65535);
    pressure_on = 1'b1;
    random_requests(120, 50);
    drain();

    write_reg(CFG_CAPACITY, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd0);
    random_requests(120, 40);
    drain();

    idling = 1'b0;
    write_reg(CFG_CAPACITY, 16'd32);
    write_reg(CFG_TIMEOUT, 16'd7);
    random_requests(120, 45);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rwb_pkg.sv
sv/retransmit_window_buffer_top.sv
sv/rwb_checker.sv
dv/retransmit_window_buffer_top_tb.sv
